// File: rtl/core/plt_pkg.sv
// Shared types and codes of the Pascal-like tokenizer.
`default_nettype none

package plt_pkg;

  // Scanner modes.
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_ID    = 4'd1;
  localparam logic [3:0] M_NUM   = 4'd2;
  localparam logic [3:0] M_CHR1  = 4'd3;
  localparam logic [3:0] M_CHR2  = 4'd4;
  localparam logic [3:0] M_STR   = 4'd5;
  localparam logic [3:0] M_CMT   = 4'd6;
  localparam logic [3:0] M_LINE  = 4'd7;
  localparam logic [3:0] M_DOT   = 4'd8;
  localparam logic [3:0] M_GT    = 4'd9;
  localparam logic [3:0] M_LT    = 4'd10;
  localparam logic [3:0] M_COL   = 4'd11;
  localparam logic [3:0] M_COLEQ = 4'd12;
  localparam logic [3:0] M_ERR   = 4'd13;

  // Result kinds.
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Token kinds.
  localparam logic [5:0] TK_EOF    = 6'd0;
  localparam logic [5:0] TK_ID     = 6'd1;
  localparam logic [5:0] TK_INT    = 6'd2;
  localparam logic [5:0] TK_CHAR   = 6'd3;
  localparam logic [5:0] TK_STR    = 6'd4;
  localparam logic [5:0] TK_CMT    = 6'd5;
  localparam logic [5:0] TK_LINE   = 6'd6;
  localparam logic [5:0] TK_PLUS   = 6'd7;
  localparam logic [5:0] TK_MINUS  = 6'd8;
  localparam logic [5:0] TK_STAR   = 6'd9;
  localparam logic [5:0] TK_SLASH  = 6'd10;
  localparam logic [5:0] TK_COMMA  = 6'd11;
  localparam logic [5:0] TK_SEMI   = 6'd12;
  localparam logic [5:0] TK_LPAREN = 6'd13;
  localparam logic [5:0] TK_RPAREN = 6'd14;
  localparam logic [5:0] TK_EQ     = 6'd15;
  localparam logic [5:0] TK_DOT    = 6'd16;
  localparam logic [5:0] TK_DOTDOT = 6'd17;
  localparam logic [5:0] TK_GT     = 6'd18;
  localparam logic [5:0] TK_GE     = 6'd19;
  localparam logic [5:0] TK_LT     = 6'd20;
  localparam logic [5:0] TK_LE     = 6'd21;
  localparam logic [5:0] TK_NE     = 6'd22;
  localparam logic [5:0] TK_COLON  = 6'd23;
  localparam logic [5:0] TK_ASSIGN = 6'd24;
  localparam logic [5:0] TK_SWAP   = 6'd25;
  localparam logic [5:0] TK_KW0    = 6'd26;

  // Error codes.
  localparam logic [2:0] ERR_UNKNOWN   = 3'd0;
  localparam logic [2:0] ERR_EMPTY_CHR = 3'd1;
  localparam logic [2:0] ERR_BAD_CHR   = 3'd2;
  localparam logic [2:0] ERR_OPEN_STR  = 3'd3;
  localparam logic [2:0] ERR_OPEN_CMT  = 3'd4;
  localparam logic [2:0] ERR_DIGIT_LET = 3'd5;

  localparam int NUM_KW = 32;
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_char;
    logic [5:0] token_kind;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [NUM_KW-1:0] alive;
    logic [3:0]        len;
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/plt_lexer.sv
// Combinational scanner step: next state and up to three results for one request.
`default_nettype none

module plt_lexer (
  input  wire plt_pkg::state_t        cur,
  input  wire logic [7:0]             char_in,
  input  wire logic                   end_of_input,
  output plt_pkg::state_t             nxt,
  output plt_pkg::res_t [2:0]         results,
  output logic [1:0]                  count
);

  localparam logic [3:0] KW_LEN [plt_pkg::NUM_KW] = '{
    4'd7, 4'd3, 4'd5, 4'd4, 4'd8, 4'd6, 4'd5, 4'd3,
    4'd6, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd2,
    4'd9, 4'd6, 4'd3, 4'd5, 4'd4, 4'd4, 4'd4, 4'd3,
    4'd3, 4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3, 4'd3
  };

  // Each keyword is right-justified; its first letter sits highest.
  localparam logic [71:0] KW_STR [plt_pkg::NUM_KW] = '{
    "program", "var", "const", "type", "function", "return", "begin", "end",
    "output", "if", "else", "then", "while", "do", "case", "of",
    "otherwise", "repeat", "for", "until", "loop", "pool", "exit", "mod",
    "and", "or", "not", "read", "succ", "pred", "chr", "eof"
  };

  function automatic logic [plt_pkg::NUM_KW-1:0] kw_keep(logic [7:0] c, logic [3:0] pos);
    logic [plt_pkg::NUM_KW-1:0] m;
    int sh;
    for (int k = 0; k < plt_pkg::NUM_KW; k++) begin
      m[k] = 1'b0;
      if (pos < KW_LEN[k]) begin
        sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        m[k] = (KW_STR[k][sh +: 8] == c);
      end
    end
    return m;
  endfunction

  function automatic logic [5:0] ident_kind(logic [plt_pkg::NUM_KW-1:0] alive, logic [3:0] len);
    logic [5:0] tk;
    tk = plt_pkg::TK_ID;
    for (int k = plt_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (alive[k] && KW_LEN[k] == len) begin
        tk = 6'(int'(plt_pkg::TK_KW0) + k);
      end
    end
    return tk;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[8'd65:8'd90], [8'd97:8'd122]}) || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic [5:0] op_token(logic [7:0] c);
    logic [5:0] tk;
    case (c)
      "+":     tk = plt_pkg::TK_PLUS;
      "-":     tk = plt_pkg::TK_MINUS;
      "*":     tk = plt_pkg::TK_STAR;
      "/":     tk = plt_pkg::TK_SLASH;
      ",":     tk = plt_pkg::TK_COMMA;
      ";":     tk = plt_pkg::TK_SEMI;
      "(":     tk = plt_pkg::TK_LPAREN;
      ")":     tk = plt_pkg::TK_RPAREN;
      "=":     tk = plt_pkg::TK_EQ;
      default: tk = plt_pkg::TK_EOF;
    endcase
    return tk;
  endfunction

  function automatic plt_pkg::res_t mk_text(logic [7:0] c);
    plt_pkg::res_t r;
    r = '0;
    r.kind = plt_pkg::KIND_TEXT;
    r.text_char = c;
    return r;
  endfunction

  function automatic plt_pkg::res_t mk_end(logic [5:0] tk);
    plt_pkg::res_t r;
    r = '0;
    r.kind = plt_pkg::KIND_END;
    r.token_kind = tk;
    return r;
  endfunction

  function automatic plt_pkg::res_t mk_err(logic [2:0] e);
    plt_pkg::res_t r;
    r = '0;
    r.kind = plt_pkg::KIND_ERR;
    r.error_code = e;
    return r;
  endfunction

  logic [plt_pkg::NUM_KW-1:0] keep_cur;
  logic [plt_pkg::NUM_KW-1:0] keep_first;
  logic [5:0]                 id_tk;
  logic [5:0]                 op_tk;
  logic [3:0]                 len_inc;

  assign keep_cur   = kw_keep(char_in, cur.len);
  assign keep_first = kw_keep(char_in, 4'd0);
  assign id_tk      = ident_kind(cur.alive, cur.len);
  assign op_tk      = op_token(char_in);
  assign len_inc    = (cur.len == 4'hF) ? cur.len : cur.len + 4'd1;

  always_comb begin
    logic [1:0] n;
    logic       restart;
    logic       stop;
    n       = 2'd0;
    restart = 1'b0;
    stop    = 1'b0;
    nxt     = cur;
    results = '0;

    if (cur.mode > plt_pkg::M_COLEQ) begin
      nxt.mode = plt_pkg::M_ERR;
    end else if (end_of_input) begin
      case (cur.mode)
        plt_pkg::M_ID: begin
          results[n] = mk_end(id_tk); n = n + 2'd1;
        end
        plt_pkg::M_NUM: begin
          results[n] = mk_end(plt_pkg::TK_INT); n = n + 2'd1;
        end
        plt_pkg::M_CHR1, plt_pkg::M_CHR2: begin
          results[n] = mk_err(plt_pkg::ERR_BAD_CHR); n = n + 2'd1; stop = 1'b1;
        end
        plt_pkg::M_STR: begin
          results[n] = mk_err(plt_pkg::ERR_OPEN_STR); n = n + 2'd1; stop = 1'b1;
        end
        plt_pkg::M_CMT: begin
          results[n] = mk_err(plt_pkg::ERR_OPEN_CMT); n = n + 2'd1; stop = 1'b1;
        end
        plt_pkg::M_LINE: begin
          results[n] = mk_end(plt_pkg::TK_LINE); n = n + 2'd1;
        end
        plt_pkg::M_DOT: begin
          results[n] = mk_end(plt_pkg::TK_DOT); n = n + 2'd1;
        end
        plt_pkg::M_GT: begin
          results[n] = mk_end(plt_pkg::TK_GT); n = n + 2'd1;
        end
        plt_pkg::M_LT: begin
          results[n] = mk_end(plt_pkg::TK_LT); n = n + 2'd1;
        end
        plt_pkg::M_COL: begin
          results[n] = mk_end(plt_pkg::TK_COLON); n = n + 2'd1;
        end
        plt_pkg::M_COLEQ: begin
          results[n] = mk_end(plt_pkg::TK_ASSIGN); n = n + 2'd1;
        end
        default: ;
      endcase
      if (stop) begin
        nxt.mode = plt_pkg::M_ERR;
      end else begin
        results[n] = mk_end(plt_pkg::TK_EOF); n = n + 2'd1;
        nxt.mode = plt_pkg::M_IDLE;
      end
    end else begin
      case (cur.mode)
        plt_pkg::M_ID: begin
          if (is_letter(char_in) || is_digit(char_in)) begin
            nxt.alive = cur.alive & keep_cur;
            nxt.len = len_inc;
            results[n] = mk_text(char_in); n = n + 2'd1;
          end else begin
            results[n] = mk_end(id_tk); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE; restart = 1'b1;
          end
        end
        plt_pkg::M_NUM: begin
          if (is_digit(char_in)) begin
            results[n] = mk_text(char_in); n = n + 2'd1;
          end else if (is_letter(char_in)) begin
            results[n] = mk_err(plt_pkg::ERR_DIGIT_LET); n = n + 2'd1;
            nxt.mode = plt_pkg::M_ERR;
          end else begin
            results[n] = mk_end(plt_pkg::TK_INT); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE; restart = 1'b1;
          end
        end
        plt_pkg::M_CHR1: begin
          if (char_in == "'") begin
            results[n] = mk_err(plt_pkg::ERR_EMPTY_CHR); n = n + 2'd1;
            nxt.mode = plt_pkg::M_ERR;
          end else begin
            results[n] = mk_text(char_in); n = n + 2'd1;
            nxt.mode = plt_pkg::M_CHR2;
          end
        end
        plt_pkg::M_CHR2: begin
          if (char_in == "'") begin
            results[n] = mk_end(plt_pkg::TK_CHAR); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_err(plt_pkg::ERR_BAD_CHR); n = n + 2'd1;
            nxt.mode = plt_pkg::M_ERR;
          end
        end
        plt_pkg::M_STR: begin
          if (char_in == "\"") begin
            results[n] = mk_end(plt_pkg::TK_STR); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_text(char_in); n = n + 2'd1;
          end
        end
        plt_pkg::M_CMT: begin
          if (char_in == "}") begin
            results[n] = mk_end(plt_pkg::TK_CMT); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_text(char_in); n = n + 2'd1;
          end
        end
        plt_pkg::M_LINE: begin
          if (char_in == "\n" || char_in == 8'h0D) begin
            results[n] = mk_end(plt_pkg::TK_LINE); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_text(char_in); n = n + 2'd1;
          end
        end
        plt_pkg::M_DOT: begin
          if (char_in == ".") begin
            results[n] = mk_text(char_in); n = n + 2'd1;
            results[n] = mk_end(plt_pkg::TK_DOTDOT); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_end(plt_pkg::TK_DOT); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE; restart = 1'b1;
          end
        end
        plt_pkg::M_GT: begin
          if (char_in == "=") begin
            results[n] = mk_text(char_in); n = n + 2'd1;
            results[n] = mk_end(plt_pkg::TK_GE); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_end(plt_pkg::TK_GT); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE; restart = 1'b1;
          end
        end
        plt_pkg::M_LT: begin
          if (char_in == "=") begin
            results[n] = mk_text(char_in); n = n + 2'd1;
            results[n] = mk_end(plt_pkg::TK_LE); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else if (char_in == ">") begin
            results[n] = mk_text(char_in); n = n + 2'd1;
            results[n] = mk_end(plt_pkg::TK_NE); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_end(plt_pkg::TK_LT); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE; restart = 1'b1;
          end
        end
        plt_pkg::M_COL: begin
          if (char_in == "=") begin
            results[n] = mk_text(char_in); n = n + 2'd1;
            nxt.mode = plt_pkg::M_COLEQ;
          end else begin
            results[n] = mk_end(plt_pkg::TK_COLON); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE; restart = 1'b1;
          end
        end
        plt_pkg::M_COLEQ: begin
          if (char_in == ":") begin
            results[n] = mk_text(char_in); n = n + 2'd1;
            results[n] = mk_end(plt_pkg::TK_SWAP); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE;
          end else begin
            results[n] = mk_end(plt_pkg::TK_ASSIGN); n = n + 2'd1;
            nxt.mode = plt_pkg::M_IDLE; restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
    end

    // The current character is scanned anew: it opens a new token, is skipped as white space, or gives an error.
    if (restart) begin
      if (char_in == " " || char_in == "\t" || char_in == 8'h0D || char_in == "\n") begin
        nxt.mode = plt_pkg::M_IDLE;
      end else if (char_in == "'") begin
        nxt.mode = plt_pkg::M_CHR1;
      end else if (char_in == "\"") begin
        nxt.mode = plt_pkg::M_STR;
      end else if (char_in == "{") begin
        nxt.mode = plt_pkg::M_CMT;
      end else if (char_in == "#") begin
        nxt.mode = plt_pkg::M_LINE;
      end else if (is_digit(char_in)) begin
        results[n] = mk_text(char_in); n = n + 2'd1;
        nxt.mode = plt_pkg::M_NUM;
      end else if (is_letter(char_in)) begin
        nxt.alive = keep_first;
        nxt.len = 4'd1;
        results[n] = mk_text(char_in); n = n + 2'd1;
        nxt.mode = plt_pkg::M_ID;
      end else if (op_tk != plt_pkg::TK_EOF) begin
        results[n] = mk_text(char_in); n = n + 2'd1;
        results[n] = mk_end(op_tk); n = n + 2'd1;
        nxt.mode = plt_pkg::M_IDLE;
      end else if (char_in == ".") begin
        results[n] = mk_text(char_in); n = n + 2'd1;
        nxt.mode = plt_pkg::M_DOT;
      end else if (char_in == ">") begin
        results[n] = mk_text(char_in); n = n + 2'd1;
        nxt.mode = plt_pkg::M_GT;
      end else if (char_in == "<") begin
        results[n] = mk_text(char_in); n = n + 2'd1;
        nxt.mode = plt_pkg::M_LT;
      end else if (char_in == ":") begin
        results[n] = mk_text(char_in); n = n + 2'd1;
        nxt.mode = plt_pkg::M_COL;
      end else begin
        results[n] = mk_err(plt_pkg::ERR_UNKNOWN); n = n + 2'd1;
        nxt.mode = plt_pkg::M_ERR;
      end
    end

    if (n != 2'd0) begin
      results[n - 2'd1].last = 1'b1;
    end
    count = n;
  end

endmodule

`default_nettype wire

// File: rtl/core/pascal_like_tokenizer.sv
// Top level of the Pascal-like tokenizer: scanner state and result queue.
// The first result of a request is offered in the cycle after the request is accepted.
// Throughput: one request per cycle while each request gives at most one result and
// out_ready is high; a request with more results holds off the next until all have left.
// Reset (synchronous, active high) returns the scanner to idle, sets the keyword
// mask to all ones, clears the identifier length and empties the result queue.
`default_nettype none

module pascal_like_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      text_char,
  output logic [5:0]      token_kind,
  output logic [2:0]      error_code,
  output logic            last
);

  // Scanner state: mode, keyword alive mask and identifier length.
  plt_pkg::state_t state;
  plt_pkg::state_t state_next;

  // Results of one request, produced in a single pass by the scanner.
  plt_pkg::res_t [2:0] step_res;
  logic [1:0]          step_cnt;

  // Result queue: entry 0 is the one on the output port. It holds the results
  // of at most one request, so it is refilled whole when a request is taken.
  plt_pkg::res_t [2:0] queue;
  logic [1:0]          cnt;

  logic in_fire;
  logic out_fire;

  plt_lexer u_lexer (
    .cur          (state),
    .char_in      (char_in),
    .end_of_input (end_of_input),
    .nxt          (state_next),
    .results      (step_res),
    .count        (step_cnt)
  );

  // A new request is taken when the queue is empty or its last entry leaves
  // in this same cycle, so a finished result never blocks the next request.
  assign in_ready  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_fire  = out_valid && out_ready;

  assign kind       = queue[0].kind;
  assign text_char  = queue[0].text_char;
  assign token_kind = queue[0].token_kind;
  assign error_code = queue[0].error_code;
  assign last       = queue[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode  <= plt_pkg::M_IDLE;
      state.alive <= '1;
      state.len   <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_fire) begin
      cnt <= step_cnt;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      queue <= step_res;
    end else if (out_fire) begin
      queue[0] <= queue[1];
      queue[1] <= queue[2];
    end
  end

  // The newest entry in the queue always closes the results of its request.
  assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd0) |-> queue[cnt - 2'd1].last)
    else $error("queued results do not end with a last flag");

  // Once an error has been reported, further requests give no results.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && state.mode == plt_pkg::M_ERR) |=> (cnt == 2'd0))
    else $error("request after an error produced results");

  // The error mode is only left through reset.
  assert property (@(posedge clk) disable iff (rst)
    (state.mode == plt_pkg::M_ERR) |=> (state.mode == plt_pkg::M_ERR))
    else $error("error mode left without reset");

  // A request is never taken while older results would be overwritten.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (cnt == 2'd0 || out_fire))
    else $error("request accepted over pending results");

endmodule

`default_nettype wire
